@@ rtl/lsas_pkg.sv @@
// Shared types and constants for the log slot address scheduler.
`timescale 1ns / 1ps

package lsas_pkg;

	localparam int ROWS_DEF = 4;
	localparam int TAG_W = 16;
	localparam int PER_W = 12;
	localparam int DEV_W = 4;
	localparam int SEC_W = 12;
	localparam int FRAME_W = 18;
	localparam int ADDR_W = 19;
	localparam int DIV_W = 12;
	localparam int PROD_W = PER_W + DEV_W + 1;
	localparam int MAX_OUT = 64;
	localparam int CNT_W = $clog2(MAX_OUT);

	localparam logic [DIV_W-1:0] HOUR_SECONDS = DIV_W'(3600);
	localparam logic [DEV_W-1:0] MAX_DEVICES = DEV_W'(15);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic op;
		logic [TAG_W-1:0] device_tag;
		logic [PER_W-1:0] period_seconds;
		logic [DEV_W-1:0] device_count;
		logic [SEC_W-1:0] seconds_in_hour;
	} in_t;

	typedef struct packed {
		logic [ADDR_W-1:0] slot_address;
		logic is_timestamp;
		logic [1:0] row_index;
		logic accepted;
		logic last;
	} out_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DIV_W-1:0] quotient;
		logic [DIV_W-1:0] remainder;
	} div_rsp_t;

endpackage

@@ rtl/lsas_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by insert and tick.
`timescale 1ns / 1ps

module lsas_div (
	input  logic clk,
	input  logic arst_n,
	input  lsas_pkg::div_req_t req,
	output lsas_pkg::div_rsp_t rsp
);

	localparam int W = lsas_pkg::DIV_W;
	localparam int CW = $clog2(W + 1);

	logic busy_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] dq_q;
	logic [W-1:0] dsr_q;

	logic [W:0] shifted;
	logic [W:0] dsr_ext;
	logic ge;
	logic [W:0] diff;
	logic [W-1:0] rem_n;

	assign shifted = {rem_q, dq_q[W-1]};
	assign dsr_ext = {1'b0, dsr_q};
	assign ge = (shifted >= dsr_ext);
	assign diff = shifted - dsr_ext;
	assign rem_n = ge ? diff[W-1:0] : shifted[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dq_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			dq_q <= {dq_q[W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quotient = dq_q;
	assign rsp.remainder = rem_q;

endmodule

@@ rtl/lsas_oreg.sv @@
// Output register holding one result beat until the sink takes it.
`timescale 1ns / 1ps

module lsas_oreg (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  lsas_pkg::out_t load_data,
	output logic can_load,
	output logic out_valid,
	input  logic out_ready,
	output lsas_pkg::out_t out_data
);

	logic valid_q;
	lsas_pkg::out_t data_q;

	assign can_load = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

@@ rtl/log_slot_address_scheduler.sv @@
// Schedule table with sequencer: inserts rows and expands ticks into slot addresses.
// Insert: result beat follows the shared divider, the multiply and the table write;
// a rejected insert goes straight to the result beat.
// Tick: divider scan of occupied rows, then multiply and add per due row, one slot per
// cycle unless the output stalls, at most 64 slots; one item is worked on at a time.
// Reset (arst_n low) empties every row and drops any pending result.
`timescale 1ns / 1ps

module log_slot_address_scheduler #(
	parameter int ROWS = lsas_pkg::ROWS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  lsas_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output lsas_pkg::out_t out_data
);

	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int TAG_W = lsas_pkg::TAG_W;
	localparam int PER_W = lsas_pkg::PER_W;
	localparam int DEV_W = lsas_pkg::DEV_W;
	localparam int SEC_W = lsas_pkg::SEC_W;
	localparam int FRAME_W = lsas_pkg::FRAME_W;
	localparam int ADDR_W = lsas_pkg::ADDR_W;
	localparam int DIV_W = lsas_pkg::DIV_W;
	localparam int PROD_W = lsas_pkg::PROD_W;
	localparam int CNT_W = lsas_pkg::CNT_W;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INS_DIV = 4'd1;
	localparam logic [3:0] S_INS_MUL = 4'd2;
	localparam logic [3:0] S_INS_WR  = 4'd3;
	localparam logic [3:0] S_INS_OUT = 4'd4;
	localparam logic [3:0] S_T_SCAN  = 4'd5;
	localparam logic [3:0] S_T_DIV   = 4'd6;
	localparam logic [3:0] S_T_PICK  = 4'd7;
	localparam logic [3:0] S_T_MUL   = 4'd8;
	localparam logic [3:0] S_T_ADD   = 4'd9;
	localparam logic [3:0] S_T_EMIT  = 4'd10;

	logic [3:0] state_q;

	// schedule table
	logic [TAG_W-1:0] tag_q [ROWS];
	logic [PER_W-1:0] period_q [ROWS];
	logic [DEV_W-1:0] devs_q [ROWS];
	logic [FRAME_W-1:0] end_q [ROWS];
	logic [DIV_W-1:0] quo_q [ROWS];
	logic [ROWS-1:0] due_q;

	logic [ROW_W-1:0] row_q;
	logic [TAG_W-1:0] tag_in_q;
	logic [PER_W-1:0] per_in_q;
	logic [DEV_W-1:0] dev_in_q;
	logic [SEC_W-1:0] secs_q;
	logic ins_ok_q;
	logic [PROD_W-1:0] prod_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DEV_W-1:0] dev_q;
	logic [CNT_W-1:0] cnt_q;

	lsas_pkg::div_req_t div_req;
	lsas_pkg::div_rsp_t div_rsp;
	lsas_pkg::out_t out_next;
	logic out_load;
	logic can_load;

	logic in_fire;
	logic [DEV_W-1:0] dev_clamped;
	logic [ROWS-1:0] occ;
	logic free_found;
	logic [ROW_W-1:0] free_idx;
	logic due_any;
	logic [ROW_W-1:0] pick_idx;
	logic row_last;
	logic [ROW_W-1:0] prev_idx;
	logic [ADDR_W-1:0] offset;
	logic [ADDR_W:0] sum;
	logic [DIV_W-1:0] mul_a;
	logic [DEV_W:0] mul_b;
	logic [PROD_W-1:0] mul_p;
	logic [ROWS-1:0] due_others;
	logic dev_done;
	logic emit_last;
	logic [ROW_W+1:0] row_wide;
	logic reject;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire = in_valid && in_ready;

	assign dev_clamped = (in_data.device_count > lsas_pkg::MAX_DEVICES) ?
		lsas_pkg::MAX_DEVICES : in_data.device_count;

	always_comb begin
		occ = '0;
		free_found = 1'b0;
		free_idx = '0;
		due_any = 1'b0;
		pick_idx = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			occ[i] = (tag_q[i] != '0);
			if (tag_q[i] == '0) begin
				free_found = 1'b1;
				free_idx = ROW_W'(i);
			end
			if (due_q[i]) begin
				due_any = 1'b1;
				pick_idx = ROW_W'(i);
			end
		end
	end

	assign reject = (in_data.device_tag == '0) || (in_data.period_seconds == '0) ||
		!free_found;

	assign row_last = (row_q == ROW_W'(ROWS - 1));

	// previous row's frame end plus one, unwrapped; zero for the first row
	assign prev_idx = (row_q == '0) ? '0 : row_q - ROW_W'(1);
	assign offset = (row_q == '0) ? '0 :
		ADDR_W'({1'b0, end_q[prev_idx]}) + ADDR_W'(1);
	assign sum = (ADDR_W + 1)'(prod_q) + (ADDR_W + 1)'(offset);

	// one multiplier: quotient times device count (insert) or devices plus one (tick)
	always_comb begin
		if (state_q == S_INS_MUL) begin
			mul_a = div_rsp.quotient;
			mul_b = {1'b0, dev_in_q};
		end else begin
			mul_a = quo_q[row_q];
			mul_b = {1'b0, devs_q[row_q]} + (DEV_W + 1)'(1);
		end
	end
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_comb begin
		div_req.start = 1'b0;
		div_req.dividend = lsas_pkg::HOUR_SECONDS;
		div_req.divisor = in_data.period_seconds;
		if (in_fire && (in_data.op == lsas_pkg::OP_INSERT) && !reject) begin
			div_req.start = 1'b1;
		end else if ((state_q == S_T_SCAN) && occ[row_q]) begin
			div_req.start = 1'b1;
			div_req.dividend = secs_q;
			div_req.divisor = period_q[row_q];
		end
	end

	lsas_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	always_comb begin
		due_others = due_q;
		due_others[row_q] = 1'b0;
	end
	assign dev_done = (dev_q == devs_q[row_q]);
	assign emit_last = (cnt_q == CNT_W'(lsas_pkg::MAX_OUT - 1)) ||
		(dev_done && (due_others == '0));

	assign row_wide = {2'b00, row_q};

	always_comb begin
		out_load = 1'b0;
		out_next.slot_address = addr_q;
		out_next.is_timestamp = (dev_q == '0);
		out_next.row_index = row_wide[1:0];
		out_next.accepted = 1'b0;
		out_next.last = emit_last;
		unique case (state_q)
			S_INS_OUT: begin
				out_load = can_load;
				out_next.slot_address = '0;
				out_next.is_timestamp = 1'b0;
				out_next.accepted = ins_ok_q;
				out_next.last = 1'b1;
			end
			S_T_EMIT: begin
				out_load = can_load;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	lsas_oreg u_oreg (
		.clk(clk),
		.arst_n(arst_n),
		.load(out_load),
		.load_data(out_next),
		.can_load(can_load),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			due_q <= '0;
			for (int i = 0; i < ROWS; i++) begin
				tag_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (in_data.op == lsas_pkg::OP_TICK) begin
							due_q <= '0;
							state_q <= S_T_SCAN;
						end else if (reject) begin
							state_q <= S_INS_OUT;
						end else begin
							state_q <= S_INS_DIV;
						end
					end
				end
				S_INS_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_INS_MUL;
					end
				end
				S_INS_MUL: begin
					state_q <= S_INS_WR;
				end
				S_INS_WR: begin
					tag_q[row_q] <= tag_in_q;
					state_q <= S_INS_OUT;
				end
				S_INS_OUT: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				S_T_SCAN: begin
					// occupied rows form a prefix, so stop at the first empty one
					state_q <= occ[row_q] ? S_T_DIV : S_T_PICK;
				end
				S_T_DIV: begin
					if (div_rsp.done) begin
						due_q[row_q] <= (div_rsp.remainder == '0);
						state_q <= row_last ? S_T_PICK : S_T_SCAN;
					end
				end
				S_T_PICK: begin
					state_q <= due_any ? S_T_MUL : S_IDLE;
				end
				S_T_MUL: begin
					state_q <= S_T_ADD;
				end
				S_T_ADD: begin
					state_q <= S_T_EMIT;
				end
				S_T_EMIT: begin
					if (can_load) begin
						if (emit_last) begin
							state_q <= S_IDLE;
						end else if (dev_done) begin
							due_q[row_q] <= 1'b0;
							state_q <= S_T_PICK;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			tag_in_q <= in_data.device_tag;
			per_in_q <= in_data.period_seconds;
			dev_in_q <= dev_clamped;
			secs_q <= in_data.seconds_in_hour;
			ins_ok_q <= !reject;
			cnt_q <= '0;
			row_q <= '0;
			if ((in_data.op == lsas_pkg::OP_INSERT) && !reject) begin
				row_q <= free_idx;
			end
		end
		if ((state_q == S_INS_MUL) || (state_q == S_T_MUL)) begin
			prod_q <= mul_p;
		end
		if (state_q == S_INS_WR) begin
			period_q[row_q] <= per_in_q;
			devs_q[row_q] <= dev_in_q;
			end_q[row_q] <= sum[FRAME_W-1:0];
		end
		if ((state_q == S_T_DIV) && div_rsp.done) begin
			quo_q[row_q] <= div_rsp.quotient;
			if (!row_last) begin
				row_q <= row_q + ROW_W'(1);
			end
		end
		if ((state_q == S_T_PICK) && due_any) begin
			row_q <= pick_idx;
		end
		if (state_q == S_T_ADD) begin
			addr_q <= sum[ADDR_W-1:0];
			dev_q <= '0;
		end
		if ((state_q == S_T_EMIT) && can_load) begin
			cnt_q <= cnt_q + CNT_W'(1);
			addr_q <= addr_q + ADDR_W'(1);
			dev_q <= dev_q + DEV_W'(1);
		end
	end

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid || out_ready))
		else $error("result beat loaded over an untaken one");

	a_occ_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((occ & (occ + ROWS'(1))) == '0))
		else $error("occupied rows are not a prefix of the table");

	a_emit_due: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_T_EMIT) |-> due_q[row_q])
		else $error("emitting slots for a row that is not due");

endmodule
